// File: hw/rtl/abs_pkg.sv
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types and constants for the analog button sense block.
// ----------------------------------------------------------------------------
package abs_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int PERIOD_W   = 16;
   localparam int STEP_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [SAMPLE_W-1:0] DEF_THRESHOLD = 12'd300;
   localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 12'd300;
   localparam logic [SAMPLE_W-1:0] RST_TARGET    = 12'd2048;
   localparam logic [SAMPLE_W-1:0] RST_DEADZONE  = 12'd50;
   localparam logic [PERIOD_W-1:0] RST_PERIOD    = 16'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_DELTA  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_TARGET   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_DEADZONE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_PERIOD = 2'd3;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_PRESSED = 2'd1,
      MODE_CAL     = 2'd2,
      MODE_ERROR   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] press_delta;
      logic [SAMPLE_W-1:0] cal_target;
      logic [SAMPLE_W-1:0] cal_deadzone;
      logic [PERIOD_W-1:0] track_period;
   } cfg_type;

   typedef struct packed {
      mode_type            mode;
      logic [SAMPLE_W-1:0] dac_code;
      logic                dac_changed;
      logic [SAMPLE_W-1:0] filtered_level;
      logic [SAMPLE_W-1:0] baseline_level;
   } rsp_type;

endpackage

// File: hw/rtl/abs_ifs.sv
// ----------------------------------------------------------------------------
// abs channel interfaces
// Valid/ready channels for readings, results and register writes.
// ----------------------------------------------------------------------------
interface abs_req_if;
   import abs_pkg::*;
   logic                valid;
   logic                ready;
   logic                action;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, action, sample, input ready);
   modport sink   (input valid, action, sample, output ready);
endinterface

interface abs_rsp_if;
   import abs_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [SAMPLE_W-1:0] dac_code;
   logic                dac_changed;
   logic [SAMPLE_W-1:0] filtered_level;
   logic [SAMPLE_W-1:0] baseline_level;

   modport source (output valid, mode, dac_code, dac_changed, filtered_level,
                   baseline_level, input ready);
   modport sink   (input valid, mode, dac_code, dac_changed, filtered_level,
                   baseline_level, output ready);
endinterface

interface abs_csr_if;
   import abs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/analog_button_sense_with_autocal.sv
// ----------------------------------------------------------------------------
// analog_button_sense_with_autocal
// A reading is held in the input register, its result in the result register.
// Throughput: one reading per cycle unless the receiver stalls; the state update
// of one reading is a single pass of logic between the input and result registers.
// Reset (synchronous): clears state, mode idle, DAC code at half scale,
// registers back to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module analog_button_sense_with_autocal #(
   parameter int DAC_MAX   = 4095,
   parameter int CAL_STEPS = 16
) (
   input  logic       clock,
   input  logic       reset,
   abs_req_if.sink    req_bus,
   abs_rsp_if.source  rsp_bus,
   abs_csr_if.sink    csr_bus
);
   import abs_pkg::*;

   cfg_type             cfg;
   rsp_type             res;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_action_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff;
   logic                advance;
   logic                fire;
   logic                req_take;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign fire          = s1_valid_ff && advance;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   abs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   abs_core #(
      .DAC_MAX   (DAC_MAX),
      .CAL_STEPS (CAL_STEPS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .action (s1_action_ff),
      .sample (s1_sample_ff),
      .res    (res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_bus.action;
         s1_sample_ff <= req_bus.sample;
      end
      if (fire) begin
         out_ff <= res;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.mode           = out_ff.mode;
   assign rsp_bus.dac_code       = out_ff.dac_code;
   assign rsp_bus.dac_changed    = out_ff.dac_changed;
   assign rsp_bus.filtered_level = out_ff.filtered_level;
   assign rsp_bus.baseline_level = out_ff.baseline_level;

endmodule

// File: hw/rtl/abs_csr.sv
// ----------------------------------------------------------------------------
// abs_csr
// Configuration register file; writes always accepted.
// ----------------------------------------------------------------------------
module abs_csr (
   input  logic            clock,
   input  logic            reset,
   abs_csr_if.sink         csr_bus,
   output abs_pkg::cfg_type cfg
);
   import abs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_bus.index)
            CSR_PRESS_DELTA:  cfg_in.press_delta  = csr_bus.data[SAMPLE_W-1:0];
            CSR_CAL_TARGET:   cfg_in.cal_target   = csr_bus.data[SAMPLE_W-1:0];
            CSR_CAL_DEADZONE: cfg_in.cal_deadzone = csr_bus.data[SAMPLE_W-1:0];
            CSR_TRACK_PERIOD: cfg_in.track_period = csr_bus.data[PERIOD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_delta  <= RST_THRESHOLD;
         cfg_ff.cal_target   <= RST_TARGET;
         cfg_ff.cal_deadzone <= RST_DEADZONE;
         cfg_ff.track_period <= RST_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/abs_core.sv
// ----------------------------------------------------------------------------
// abs_core
// Calibration search, IIR filter, baseline tracking and press detection.
// Computes the result and next state for one reading; state commits on fire.
// ----------------------------------------------------------------------------
module abs_core #(
   parameter int DAC_MAX   = 4095,
   parameter int CAL_STEPS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  abs_pkg::cfg_type              cfg,
   input  logic                          fire,
   input  logic                          action,
   input  logic [abs_pkg::SAMPLE_W-1:0]  sample,
   output abs_pkg::rsp_type              res
);
   import abs_pkg::*;

   localparam int DW = $clog2(DAC_MAX + 1);
   localparam logic [DW-1:0]     DAC_TOP  = DW'(DAC_MAX);
   localparam logic [DW-1:0]     DAC_HALF = DW'(DAC_MAX / 2);
   localparam logic [STEP_W-1:0] STEP_LIM = STEP_W'(CAL_STEPS);

   mode_type            mode_ff,   mode_in;
   logic                final_ff,  final_in;
   logic [SAMPLE_W-1:0] filt_ff,   filt_in;
   logic [SAMPLE_W-1:0] base_ff,   base_in;
   logic [PERIOD_W-1:0] track_ff,  track_in;
   logic [DW:0]         low_ff,    low_in;
   logic [DW-1:0]       high_ff,   high_in;
   logic [DW-1:0]       mid_ff,    mid_in;
   logic [STEP_W-1:0]   step_ff,   step_in;
   logic [DW-1:0]       dac_ff,    dac_in;
   logic                changed;

   // acceptance window, lower bound saturating at zero
   logic [SAMPLE_W-1:0] win_lo;
   logic [SAMPLE_W:0]   win_hi;
   logic                in_win;

   assign win_lo = (cfg.cal_target > cfg.cal_deadzone) ?
                   cfg.cal_target - cfg.cal_deadzone : '0;
   assign win_hi = {1'b0, cfg.cal_target} + {1'b0, cfg.cal_deadzone};
   assign in_win = (sample >= win_lo) && ({1'b0, sample} <= win_hi);

   // filter and thresholds
   logic [SAMPLE_W-1:0] thr;
   logic [SAMPLE_W+1:0] iir_sum;
   logic [SAMPLE_W-1:0] filt_new;
   logic [SAMPLE_W-1:0] base_seed;
   logic [PERIOD_W-1:0] track_inc;
   logic [SAMPLE_W-1:0] base_trk;

   assign thr      = (cfg.press_delta != '0) ? cfg.press_delta : DEF_THRESHOLD;
   assign iir_sum  = {2'b00, sample} + {2'b00, filt_ff} + {1'b0, filt_ff, 1'b0};
   assign filt_new = (filt_ff == '0) ? sample : iir_sum[SAMPLE_W+1:2];
   assign base_seed = (base_ff == '0) ? filt_new : base_ff;
   assign track_inc = track_ff + 1'b1;

   always_comb begin
      base_trk = base_seed;
      if (filt_new > base_seed) begin
         base_trk = base_seed + 1'b1;
      end else if (filt_new < base_seed) begin
         base_trk = base_seed - 1'b1;
      end
   end

   // search step
   logic [DW:0]         low_step;
   logic [DW-1:0]       high_step;
   logic                zero_stop;
   logic [STEP_W-1:0]   step_inc;
   logic [DW+1:0]       mid_sum;
   logic [DW-1:0]       mid_new;
   logic                stop;

   always_comb begin
      low_step  = low_ff;
      high_step = high_ff;
      zero_stop = 1'b0;
      if (sample > cfg.cal_target) begin
         low_step = {1'b0, mid_ff} + 1'b1;
      end else if (mid_ff == '0) begin
         zero_stop = 1'b1;
      end else begin
         high_step = mid_ff - 1'b1;
      end
   end

   assign step_inc = step_ff + 1'b1;
   assign mid_sum  = {1'b0, low_step} + {2'b00, high_step};
   assign mid_new  = mid_sum[DW:1];
   assign stop     = zero_stop || (low_step > {1'b0, high_step}) || (step_inc >= STEP_LIM);

   always_comb begin
      mode_in  = mode_ff;
      final_in = final_ff;
      filt_in  = filt_ff;
      base_in  = base_ff;
      track_in = track_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      mid_in   = mid_ff;
      step_in  = step_ff;
      dac_in   = dac_ff;
      changed  = 1'b0;

      if (action) begin
         mode_in  = MODE_CAL;
         final_in = 1'b0;
         step_in  = '0;
         low_in   = '0;
         high_in  = DAC_TOP;
         mid_in   = DAC_HALF;
         dac_in   = DAC_HALF;
         changed  = 1'b1;
      end else if (mode_ff == MODE_CAL) begin
         filt_in = sample;
         dac_in  = mid_ff;
         if (final_ff || in_win) begin
            final_in = 1'b0;
            if (in_win) begin
               mode_in  = MODE_IDLE;
               base_in  = sample;
               track_in = '0;
            end else begin
               mode_in  = MODE_ERROR;
            end
         end else begin
            low_in  = low_step;
            high_in = high_step;
            step_in = step_inc;
            changed = 1'b1;
            if (stop) begin
               final_in = 1'b1;
            end else begin
               mid_in = mid_new;
               dac_in = mid_new;
            end
         end
      end else begin
         filt_in = filt_new;
         base_in = base_seed;
         unique case (mode_ff)
            MODE_IDLE: begin
               track_in = track_inc;
               if (track_inc >= cfg.track_period) begin
                  track_in = '0;
                  base_in  = base_trk;
               end
               if ({1'b0, filt_new} > {1'b0, base_in} + {1'b0, thr}) begin
                  mode_in = MODE_PRESSED;
               end
            end
            MODE_PRESSED: begin
               if ({1'b0, filt_new} < {1'b0, base_seed} + {2'b00, thr[SAMPLE_W-1:1]}) begin
                  mode_in  = MODE_IDLE;
                  track_in = '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         final_ff <= 1'b0;
         filt_ff  <= '0;
         base_ff  <= '0;
         track_ff <= '0;
         low_ff   <= '0;
         high_ff  <= DAC_TOP;
         mid_ff   <= '0;
         step_ff  <= '0;
         dac_ff   <= DAC_HALF;
      end else if (fire) begin
         mode_ff  <= mode_in;
         final_ff <= final_in;
         filt_ff  <= filt_in;
         base_ff  <= base_in;
         track_ff <= track_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         mid_ff   <= mid_in;
         step_ff  <= step_in;
         dac_ff   <= dac_in;
      end
   end

   assign res.mode           = mode_in;
   assign res.dac_code       = SAMPLE_W'(dac_in);
   assign res.dac_changed    = changed;
   assign res.filtered_level = filt_in;
   assign res.baseline_level = base_in;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the analog button sense block. Readings and
// calibration commands are sent in random bursts. Each accepted beat is
// run through a bit-exact model of the filter, baseline tracker,
// press/release detector and DAC search, and every result beat is
// compared field by field. The register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import abs_pkg::*;

   localparam int DAC_TOP    = 4095;
   localparam int STEP_LIMIT = 16;
   localparam int SAMPLE_TOP = (1 << SAMPLE_W) - 1;

   typedef struct packed {
      logic                action;
      logic [SAMPLE_W-1:0] level;
   } sense_item_type;

   logic clock;
   logic reset;

   abs_req_if req_bus();
   abs_rsp_if rsp_bus();
   abs_csr_if csr_bus();

   analog_button_sense_with_autocal #(
      .DAC_MAX   (DAC_TOP),
      .CAL_STEPS (STEP_LIMIT)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // model state
   cfg_type        sense_cfg;
   mode_type       cur_mode;
   bit             verify_pending;
   int unsigned    filt_lvl;
   int unsigned    base_lvl;
   int unsigned    track_cnt;
   int unsigned    span_lo;
   int unsigned    span_hi;
   int unsigned    span_mid;
   int unsigned    trial_cnt;
   int unsigned    bias_code;

   sense_item_type sense_items[$];
   sense_item_type sent_items[$];
   sense_item_type cur_item;
   sense_item_type got_item;
   rsp_type        want;
   int             queued_cnt = 0;
   int             accepted_cnt = 0;
   int             checked_cnt = 0;
   int             error_cnt = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   logic [7:0]     stall_pat;
   logic [5:0]     stall_tick;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4ms;
      $display("FAILURE");
      $finish;
   end

   function automatic void model_reset();
      sense_cfg      = '{RST_THRESHOLD, RST_TARGET, RST_DEADZONE, RST_PERIOD};
      cur_mode       = MODE_IDLE;
      verify_pending = 1'b0;
      filt_lvl       = 0;
      base_lvl       = 0;
      track_cnt      = 0;
      span_lo        = 0;
      span_hi        = DAC_TOP;
      span_mid       = 0;
      trial_cnt      = 0;
      bias_code      = DAC_TOP / 2;
   endfunction

   function automatic bit near_target(int unsigned v);
      int unsigned tgt, dz, lo;
      tgt = 32'(sense_cfg.cal_target);
      dz  = 32'(sense_cfg.cal_deadzone);
      lo  = (tgt > dz) ? tgt - dz : 0;
      return v >= lo && v <= tgt + dz;
   endfunction

   function automatic void lock_baseline(int unsigned v);
      cur_mode       = MODE_IDLE;
      verify_pending = 1'b0;
      base_lvl       = v;
      track_cnt      = 0;
   endfunction

   function automatic rsp_type sense_step(sense_item_type it);
      int unsigned v, thr;
      bit          stop;
      bit          changed;
      rsp_type     r;
      v       = 32'(it.level);
      changed = 1'b0;
      stop    = 1'b0;
      if (it.action) begin
         cur_mode       = MODE_CAL;
         verify_pending = 1'b0;
         trial_cnt      = 0;
         span_lo        = 0;
         span_hi        = DAC_TOP;
         span_mid       = (span_lo + span_hi) >> 1;
         bias_code      = span_mid;
         changed        = 1'b1;
      end else if (cur_mode == MODE_CAL) begin
         filt_lvl  = v;
         bias_code = span_mid;
         if (verify_pending) begin
            if (near_target(v)) begin
               lock_baseline(v);
            end else begin
               cur_mode       = MODE_ERROR;
               verify_pending = 1'b0;
            end
         end else if (near_target(v)) begin
            lock_baseline(v);
         end else begin
            if (v > 32'(sense_cfg.cal_target)) begin
               span_lo = span_mid + 1;
            end else if (span_mid == 0) begin
               stop = 1'b1;
            end else begin
               span_hi = span_mid - 1;
            end
            trial_cnt = (trial_cnt + 1) & 32'h1F;
            if (span_lo > span_hi || trial_cnt >= STEP_LIMIT) stop = 1'b1;
            // on stop the last trial code is re-issued for one more check
            if (stop) begin
               verify_pending = 1'b1;
            end else begin
               span_mid  = (span_lo + span_hi) >> 1;
               bias_code = span_mid;
            end
            changed = 1'b1;
         end
      end else begin
         thr = (sense_cfg.press_delta != 0) ? 32'(sense_cfg.press_delta)
                                            : 32'(DEF_THRESHOLD);
         if (filt_lvl == 0) begin
            filt_lvl = v;
         end else begin
            filt_lvl = ((v + 3 * filt_lvl) >> 2) & 32'hFFF;
         end
         if (base_lvl == 0) base_lvl = filt_lvl;
         if (cur_mode == MODE_IDLE) begin
            track_cnt = (track_cnt + 1) & 32'hFFFF;
            if (track_cnt >= 32'(sense_cfg.track_period)) begin
               track_cnt = 0;
               if (filt_lvl > base_lvl) base_lvl = (base_lvl + 1) & 32'hFFF;
               else if (filt_lvl < base_lvl) base_lvl = base_lvl - 1;
            end
            if (filt_lvl > base_lvl + thr) cur_mode = MODE_PRESSED;
         end else if (cur_mode == MODE_PRESSED) begin
            if (filt_lvl < base_lvl + (thr >> 1)) begin
               cur_mode  = MODE_IDLE;
               track_cnt = 0;
            end
         end
      end
      r.mode           = cur_mode;
      r.dac_code       = SAMPLE_W'(bias_code & 32'hFFF);
      r.dac_changed    = changed;
      r.filtered_level = SAMPLE_W'(filt_lvl);
      r.baseline_level = SAMPLE_W'(base_lvl);
      return r;
   endfunction

   // stimulus builders
   function automatic void push_item(bit act, int unsigned lvl);
      sense_item_type it;
      it.action = act;
      it.level  = SAMPLE_W'(lvl);
      sense_items.push_back(it);
      queued_cnt++;
   endfunction

   // resting level with noise, presses of random length, rare wild readings
   function automatic void queue_readings(int n, int unsigned rest, int unsigned amp,
                                          int unsigned cal_pct);
      int unsigned lvl;
      int unsigned held;
      held = 0;
      for (int i = 0; i < n; i++) begin
         if (held == 0 && $urandom_range(0, 39) == 0) held = $urandom_range(5, 40);
         lvl = rest + $urandom_range(0, 20);
         if (held != 0) begin
            lvl  = lvl + amp;
            held = held - 1;
         end
         if ($urandom_range(0, 49) == 0) lvl = $urandom_range(0, SAMPLE_TOP);
         if (lvl > SAMPLE_TOP) lvl = SAMPLE_TOP;
         push_item($urandom_range(0, 99) < cal_pct, lvl);
      end
   endfunction

   // full-range readings, some of them inside the calibration window
   function automatic void queue_random(int n, int unsigned cal_pct);
      int unsigned lvl, tgt, dz;
      tgt = 32'(sense_cfg.cal_target);
      dz  = 32'(sense_cfg.cal_deadzone);
      for (int i = 0; i < n; i++) begin
         lvl = $urandom_range(0, SAMPLE_TOP);
         if ($urandom_range(0, 7) == 0) begin
            lvl = ((tgt > dz) ? tgt - dz : 0) + $urandom_range(0, 2 * dz);
            if (lvl > SAMPLE_TOP) lvl = SAMPLE_TOP;
         end
         push_item($urandom_range(0, 99) < cal_pct, lvl);
      end
   endfunction

   // low readings drive the search down until it collapses at code zero
   function automatic void queue_collapse(int n);
      push_item(1'b1, 0);
      for (int i = 0; i < n; i++) begin
         push_item(1'b0, $urandom_range(0, 50));
      end
   endfunction

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic write_cfg(logic [SAMPLE_W-1:0] thr_val, logic [SAMPLE_W-1:0] tgt_val,
                            logic [SAMPLE_W-1:0] dz_val, logic [PERIOD_W-1:0] per_val);
      csr_put(CSR_PRESS_DELTA, CSR_DATA_W'(thr_val));
      csr_put(CSR_CAL_TARGET, CSR_DATA_W'(tgt_val));
      csr_put(CSR_CAL_DEADZONE, CSR_DATA_W'(dz_val));
      csr_put(CSR_TRACK_PERIOD, per_val);
      csr_bus.valid <= 1'b0;
      sense_cfg.press_delta  = thr_val;
      sense_cfg.cal_target   = tgt_val;
      sense_cfg.cal_deadzone = dz_val;
      sense_cfg.track_period = per_val;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (sense_items.size() != 0 || req_bus.valid || sent_items.size() != 0);
      @(posedge clock);
   endtask

   task automatic report_error(string what, logic [15:0] exp_val, logic [15:0] got_val);
      error_cnt++;
      $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, exp_val, got_val);
   endtask

   initial begin
      reset = 1'b1;
      model_reset();
      @(posedge clock);
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_PRESS_DELTA;
      csr_bus.data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      queue_readings(300, 1000, 500, 0);
      wait_drained();
      queue_random(250, 4);
      wait_drained();

      write_cfg(12'd0, 12'd100, 12'd0, 16'd1);
      queue_collapse(20);
      queue_readings(250, 90, 400, 5);
      wait_drained();

      write_cfg(12'd4095, 12'd4095, 12'd4095, 16'd0);
      queue_readings(250, 3000, 1000, 5);
      wait_drained();

      write_cfg(12'd40, 12'd0, 12'd10, 16'd65535);
      queue_readings(250, 200, 100, 4);
      wait_drained();

      write_cfg(12'd300, 12'd2048, 12'd50, 16'd3);
      queue_random(350, 8);
      wait_drained();

      if (error_cnt == 0 && checked_cnt == queued_cnt && accepted_cnt == queued_cnt) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // driver: bursts of beats with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid  <= 1'b0;
         req_bus.action <= 1'b0;
         req_bus.sample <= '0;
         burst_left = $urandom_range(1, 16);
         gap_left   = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            sent_items.push_back(cur_item);
            accepted_cnt++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (sense_items.size() != 0) begin
               cur_item = sense_items.pop_front();
               req_bus.valid  <= 1'b1;
               req_bus.action <= cur_item.action;
               req_bus.sample <= cur_item.level;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stalls: a new ready pattern each time the 6-bit tick counter wraps
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_pat  = 8'hFF;
         stall_tick = '0;
      end else begin
         if (stall_tick == '0) begin
            stall_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         end
         rsp_bus.ready <= stall_pat[stall_tick[2:0]];
         stall_tick = stall_tick + 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (sent_items.size() == 0) begin
            report_error("unexpected beat", 16'd0, 16'd1);
         end else begin
            got_item = sent_items.pop_front();
            want     = sense_step(got_item);
            checked_cnt++;
            if (rsp_bus.mode != want.mode)
               report_error("mode", 16'(want.mode), 16'(rsp_bus.mode));
            if (rsp_bus.dac_code != want.dac_code)
               report_error("dac_code", 16'(want.dac_code), 16'(rsp_bus.dac_code));
            if (rsp_bus.dac_changed != want.dac_changed)
               report_error("dac_changed", 16'(want.dac_changed), 16'(rsp_bus.dac_changed));
            if (rsp_bus.filtered_level != want.filtered_level)
               report_error("filtered_level", 16'(want.filtered_level),
                            16'(rsp_bus.filtered_level));
            if (rsp_bus.baseline_level != want.baseline_level)
               report_error("baseline_level", 16'(want.baseline_level),
                            16'(rsp_bus.baseline_level));
         end
      end
   end

endmodule
